### src/evr_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, types and the Q30 product helper for the Euler rotation block.
package evr_pkg;

	localparam int COORD_W = 32;
	localparam int ANGLE_W = 16;
	localparam int FRAC = 30;
	localparam int Q_W = 32;              // signed Q2.30 sine/cosine and matrix products
	localparam int U_W = FRAC + 1;        // quarter-wave argument, 0 .. 2^30
	localparam int P_W = 32;              // Horner partial result
	localparam int MAT_W = Q_W + 1;       // matrix entry, sum of two Q30 products
	localparam int PROD_W = COORD_W + MAT_W;
	localparam int ACC_W = PROD_W + 2;
	localparam int SHIFT_W = ACC_W - FRAC;
	localparam int FRONT_LAT = 10;        // angle in to front entry out
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [Q_W-1:0] ONE_Q30 = Q_W'(64'd1 << FRAC);
	localparam logic [P_W-1:0] POLY_A9 = 32'd172272;
	// Horner coefficients in the order they are applied
	localparam logic [P_W-1:0] POLY_COEF [4] = '{32'd5026995, 32'd85569306,
		32'd693598669, 32'd1686629713};

	typedef enum logic [1:0] {
		CMD_ROT_X = 2'd0,
		CMD_ROT_Y = 2'd1,
		CMD_ROT_Z = 2'd2,
		CMD_EULER = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [2:0][COORD_W-1:0] vec;
		logic [COORD_W-1:0] w;
	} item_t;

	typedef struct packed {
		logic [8:0][MAT_W-1:0] mat;
		logic [2:0][COORD_W-1:0] vec;
		logic [COORD_W-1:0] w;
	} entry_t;

	// Q30 product rounded half up (floor of product + 2^29)
	function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
		input logic signed [Q_W-1:0] b);
		logic signed [2*Q_W-1:0] p;
		p = a * b;
		p = p + $signed((2*Q_W)'(64'd1 << (FRAC - 1)));
		return p[FRAC+Q_W-1:FRAC];
	endfunction

endpackage

### src/evr_sincos.sv
`timescale 1ns / 1ps
// Pipelined quarter-wave polynomial sine and cosine of one binary angle.
module evr_sincos (
	input  logic                             clk,
	input  logic [evr_pkg::ANGLE_W-1:0]      angle,
	output logic signed [evr_pkg::Q_W-1:0]   sin_val,
	output logic signed [evr_pkg::Q_W-1:0]   cos_val
);

	localparam int H_W = evr_pkg::U_W + evr_pkg::P_W;

	logic [1:0]                  quad_c [2];
	logic [evr_pkg::FRAC-1:0]    rem_c;
	logic [evr_pkg::U_W-1:0]     u_c [2];
	logic [2*evr_pkg::U_W-1:0]   sq_c [2];
	logic [H_W-1:0]              hp_c [2][4];
	logic [H_W-1:0]              fin_c [2];
	logic [H_W-evr_pkg::FRAC-1:0] mag_c [2];
	logic [evr_pkg::Q_W-1:0]     clip_c [2];

	logic [evr_pkg::U_W-1:0]     u_q [2][6];
	logic                        neg_q [2][6];
	logic [evr_pkg::U_W-1:0]     u2_q [2][4];
	logic [evr_pkg::P_W-1:0]     p_q [2][4];
	logic signed [evr_pkg::Q_W-1:0] val_q [2];

	// lane 0 is sine, lane 1 is cosine (quadrant advanced by one)
	assign rem_c = {angle[evr_pkg::ANGLE_W-3:0], {(32 - evr_pkg::ANGLE_W){1'b0}}};

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			quad_c[l] = angle[evr_pkg::ANGLE_W-1:evr_pkg::ANGLE_W-2] + 2'(l);
			u_c[l] = quad_c[l][0] ? (evr_pkg::U_W'(evr_pkg::ONE_Q30) - {1'b0, rem_c})
				: {1'b0, rem_c};
			sq_c[l] = u_q[l][0] * u_q[l][0];
			for (int k = 0; k < 4; k++) begin
				hp_c[l][k] = u2_q[l][k] * ((k == 0) ? evr_pkg::POLY_A9 : p_q[l][(k+3)%4]);
			end
			fin_c[l] = u_q[l][5] * p_q[l][3];
			mag_c[l] = fin_c[l][H_W-1:evr_pkg::FRAC];
			clip_c[l] = (mag_c[l] > (H_W-evr_pkg::FRAC)'(evr_pkg::ONE_Q30))
				? evr_pkg::ONE_Q30 : mag_c[l][evr_pkg::Q_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			u_q[l][0] <= u_c[l];
			neg_q[l][0] <= quad_c[l][1];
			for (int k = 1; k < 6; k++) begin
				u_q[l][k] <= u_q[l][k-1];
				neg_q[l][k] <= neg_q[l][k-1];
			end
			u2_q[l][0] <= sq_c[l][evr_pkg::FRAC+evr_pkg::U_W-1:evr_pkg::FRAC];
			for (int k = 1; k < 4; k++) begin
				u2_q[l][k] <= u2_q[l][k-1];
			end
			for (int k = 0; k < 4; k++) begin
				p_q[l][k] <= evr_pkg::POLY_COEF[k]
					- hp_c[l][k][evr_pkg::FRAC+evr_pkg::P_W-1:evr_pkg::FRAC];
			end
			val_q[l] <= neg_q[l][5] ? -$signed(clip_c[l]) : $signed(clip_c[l]);
		end
	end

	assign sin_val = val_q[0];
	assign cos_val = val_q[1];

endmodule

### src/evr_front.sv
`timescale 1ns / 1ps
// Front end: takes transactions, runs sine/cosine and builds the rotation matrix per cmd.
module evr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  evr_pkg::item_t                item,
	input  logic [evr_pkg::ANGLE_W-1:0]   angle_x,
	input  logic [evr_pkg::ANGLE_W-1:0]   angle_y,
	input  logic [evr_pkg::ANGLE_W-1:0]   angle_z,
	output evr_pkg::entry_t               ent,
	output logic                          ent_vld
);

	localparam int MW = evr_pkg::MAT_W;

	logic signed [evr_pkg::Q_W-1:0] sx, cx, sy, cy, sz, cz;
	logic [evr_pkg::FRONT_LAT-1:0] vld_q;
	evr_pkg::item_t item_q [evr_pkg::FRONT_LAT-1];

	// stage m1: first-level products
	logic signed [evr_pkg::Q_W-1:0] czsy_s1, szsy_s1, czcy_s1, szcy_s1, cysx_s1, cycx_s1;
	logic signed [evr_pkg::Q_W-1:0] szcx_s1, szsx_s1, czcx_s1, czsx_s1;
	logic signed [evr_pkg::Q_W-1:0] sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	// stage m2: triple products
	logic signed [evr_pkg::Q_W-1:0] czsysx_s2, czsycx_s2, szsysx_s2, szsycx_s2;
	logic signed [evr_pkg::Q_W-1:0] czcy_s2, szcy_s2, cysx_s2, cycx_s2;
	logic signed [evr_pkg::Q_W-1:0] szcx_s2, szsx_s2, czcx_s2, czsx_s2;
	logic signed [evr_pkg::Q_W-1:0] sx_s2, cx_s2, sy_s2, cy_s2, sz_s2, cz_s2;

	logic [8:0][MW-1:0] mat_c;
	evr_pkg::item_t     it_c;

	evr_sincos u_sc_x (.clk(clk), .angle(angle_x), .sin_val(sx), .cos_val(cx));
	evr_sincos u_sc_y (.clk(clk), .angle(angle_y), .sin_val(sy), .cos_val(cy));
	evr_sincos u_sc_z (.clk(clk), .angle(angle_z), .sin_val(sz), .cos_val(cz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[evr_pkg::FRONT_LAT-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		item_q[0] <= item;
		for (int k = 1; k < evr_pkg::FRONT_LAT - 1; k++) begin
			item_q[k] <= item_q[k-1];
		end
		czsy_s1 <= evr_pkg::qmul(cz, sy);
		szsy_s1 <= evr_pkg::qmul(sz, sy);
		czcy_s1 <= evr_pkg::qmul(cz, cy);
		szcy_s1 <= evr_pkg::qmul(sz, cy);
		cysx_s1 <= evr_pkg::qmul(cy, sx);
		cycx_s1 <= evr_pkg::qmul(cy, cx);
		szcx_s1 <= evr_pkg::qmul(sz, cx);
		szsx_s1 <= evr_pkg::qmul(sz, sx);
		czcx_s1 <= evr_pkg::qmul(cz, cx);
		czsx_s1 <= evr_pkg::qmul(cz, sx);
		sx_s1 <= sx; cx_s1 <= cx; sy_s1 <= sy; cy_s1 <= cy; sz_s1 <= sz; cz_s1 <= cz;

		czsysx_s2 <= evr_pkg::qmul(czsy_s1, sx_s1);
		czsycx_s2 <= evr_pkg::qmul(czsy_s1, cx_s1);
		szsysx_s2 <= evr_pkg::qmul(szsy_s1, sx_s1);
		szsycx_s2 <= evr_pkg::qmul(szsy_s1, cx_s1);
		czcy_s2 <= czcy_s1; szcy_s2 <= szcy_s1; cysx_s2 <= cysx_s1; cycx_s2 <= cycx_s1;
		szcx_s2 <= szcx_s1; szsx_s2 <= szsx_s1; czcx_s2 <= czcx_s1; czsx_s2 <= czsx_s1;
		sx_s2 <= sx_s1; cx_s2 <= cx_s1; sy_s2 <= sy_s1; cy_s2 <= cy_s1;
		sz_s2 <= sz_s1; cz_s2 <= cz_s1;

		ent.mat <= mat_c;
		ent.vec <= it_c.vec;
		ent.w <= it_c.w;
	end

	assign it_c = item_q[evr_pkg::FRONT_LAT-2];

	always_comb begin
		mat_c = '0;
		case (it_c.cmd)
			evr_pkg::CMD_ROT_X: begin
				mat_c[0] = MW'(evr_pkg::ONE_Q30);
				mat_c[4] = MW'(cx_s2);
				mat_c[5] = -MW'(sx_s2);
				mat_c[7] = MW'(sx_s2);
				mat_c[8] = MW'(cx_s2);
			end
			evr_pkg::CMD_ROT_Y: begin
				mat_c[0] = MW'(cy_s2);
				mat_c[2] = MW'(sy_s2);
				mat_c[4] = MW'(evr_pkg::ONE_Q30);
				mat_c[6] = -MW'(sy_s2);
				mat_c[8] = MW'(cy_s2);
			end
			evr_pkg::CMD_ROT_Z: begin
				mat_c[0] = MW'(cz_s2);
				mat_c[1] = -MW'(sz_s2);
				mat_c[3] = MW'(sz_s2);
				mat_c[4] = MW'(cz_s2);
				mat_c[8] = MW'(evr_pkg::ONE_Q30);
			end
			evr_pkg::CMD_EULER: begin
				mat_c[0] = MW'(czcy_s2);
				mat_c[1] = MW'(czsysx_s2) - MW'(szcx_s2);
				mat_c[2] = MW'(czsycx_s2) + MW'(szsx_s2);
				mat_c[3] = MW'(szcy_s2);
				mat_c[4] = MW'(szsysx_s2) + MW'(czcx_s2);
				mat_c[5] = MW'(szsycx_s2) - MW'(czsx_s2);
				mat_c[6] = -MW'(sy_s2);
				mat_c[7] = MW'(cysx_s2);
				mat_c[8] = MW'(cycx_s2);
			end
			default: mat_c = '0;
		endcase
	end

	assign ent_vld = vld_q[evr_pkg::FRONT_LAT-1];

endmodule

### src/evr_fifo.sv
`timescale 1ns / 1ps
// Small queue between front and back; pops whenever it holds an entry, registered read.
module evr_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  evr_pkg::entry_t  din,
	output logic             full,
	output evr_pkg::entry_t  dout,
	output logic             dout_vld
);

	evr_pkg::entry_t           mem [evr_pkg::FIFO_DEPTH];
	logic [evr_pkg::PTR_W-1:0] wr_q, rd_q;
	logic [evr_pkg::PTR_W:0]   count_q;
	logic                      pop;

	assign pop = (count_q != '0);
	assign full = (count_q == (evr_pkg::PTR_W+1)'(evr_pkg::FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
			dout_vld <= 1'b0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + (evr_pkg::PTR_W+1)'(push) - (evr_pkg::PTR_W+1)'(pop);
			dout_vld <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= din;
		if (pop) dout <= mem[rd_q];
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (evr_pkg::PTR_W+1)'(evr_pkg::FIFO_DEPTH))
		else $error("queue count out of range");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow push");

endmodule

### src/evr_back.sv
`timescale 1ns / 1ps
// Back end: matrix times vector, rounding and saturation, three stages.
module evr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  evr_pkg::entry_t             ent,
	input  logic                        ent_vld,
	output logic                        done,
	output logic [evr_pkg::COORD_W-1:0] out_x,
	output logic [evr_pkg::COORD_W-1:0] out_y,
	output logic [evr_pkg::COORD_W-1:0] out_z,
	output logic [evr_pkg::COORD_W-1:0] out_w
);

	localparam int CW = evr_pkg::COORD_W;
	localparam int SW = evr_pkg::SHIFT_W;
	localparam logic signed [SW-1:0] MAX_V = SW'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [SW-1:0] MIN_V = ~MAX_V;

	logic signed [evr_pkg::PROD_W-1:0] prod_s1 [3][3];
	logic [CW-1:0]                     w_s1, w_s2;
	logic                              vld_s1, vld_s2;
	logic signed [SW-1:0]              sh_s2 [3];
	logic signed [evr_pkg::ACC_W-1:0]  acc_c [3];
	logic [CW-1:0]                     sat_c [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc_c[r] = evr_pkg::ACC_W'(prod_s1[r][0]) + evr_pkg::ACC_W'(prod_s1[r][1])
				+ evr_pkg::ACC_W'(prod_s1[r][2])
				+ $signed(evr_pkg::ACC_W'(64'd1 << (evr_pkg::FRAC - 1)));
			if (sh_s2[r] > MAX_V) sat_c[r] = MAX_V[CW-1:0];
			else if (sh_s2[r] < MIN_V) sat_c[r] = MIN_V[CW-1:0];
			else sat_c[r] = sh_s2[r][CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= ent_vld;
			vld_s2 <= vld_s1;
			done <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= $signed(ent.vec[2-c]) * $signed(ent.mat[3*r+c]);
			end
			sh_s2[r] <= acc_c[r][evr_pkg::ACC_W-1:evr_pkg::FRAC];
		end
		w_s1 <= ent.w;
		w_s2 <= w_s1;
		out_x <= sat_c[0];
		out_y <= sat_c[1];
		out_z <= sat_c[2];
		out_w <= w_s2;
	end

endmodule

### src/euler_vector_rotation.sv
`timescale 1ns / 1ps
// Top level of the Euler ZYX vector rotation block.
//
// Usage: drive cmd, vec_x/y/z/w and angle_x/y/z with start high; the transaction
// is taken at a rising edge where start is high and busy is low. cmd selects a
// rotation about x, y or z alone, or the full Rz*Ry*Rx product. Coordinates are
// signed Q16.16, angles are binary angles (2^16 is one turn).
// Each result appears on out_x/y/z/w for exactly one cycle with done high.
// Path: a transaction passes the sine/cosine polynomial, the matrix build, the
// queue, and the multiply, sum/round and saturate stages before done is high.
// Throughput: one transaction per cycle, sustained; every stage is pipelined
// and the queue drains one entry per cycle, so busy stays low in operation.
// Reset (arst_n low) clears all valid bits and the queue pointers; transactions
// in flight are dropped. The receiver cannot stall: results are not held.
// out_w is vec_w unchanged; rotated coordinates saturate at the 32-bit bounds.
module euler_vector_rotation (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        cmd,
	input  logic signed [evr_pkg::COORD_W-1:0] vec_x,
	input  logic signed [evr_pkg::COORD_W-1:0] vec_y,
	input  logic signed [evr_pkg::COORD_W-1:0] vec_z,
	input  logic signed [evr_pkg::COORD_W-1:0] vec_w,
	input  logic [evr_pkg::ANGLE_W-1:0]       angle_x,
	input  logic [evr_pkg::ANGLE_W-1:0]       angle_y,
	input  logic [evr_pkg::ANGLE_W-1:0]       angle_z,
	output logic                              done,
	output logic signed [evr_pkg::COORD_W-1:0] out_x,
	output logic signed [evr_pkg::COORD_W-1:0] out_y,
	output logic signed [evr_pkg::COORD_W-1:0] out_z,
	output logic signed [evr_pkg::COORD_W-1:0] out_w
);

	logic            accept;
	evr_pkg::item_t  item;
	evr_pkg::entry_t front_ent, back_ent;
	logic            front_vld, back_vld;
	logic            q_full;

	// busy follows the queue's full flag; the back end never holds off
	assign busy = q_full;
	assign accept = start & ~busy;

	assign item.cmd = evr_pkg::cmd_t'(cmd);
	assign item.vec = {vec_x, vec_y, vec_z};
	assign item.w = vec_w;

	evr_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .item(item),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.ent(front_ent), .ent_vld(front_vld)
	);

	evr_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(front_vld), .din(front_ent),
		.full(q_full), .dout(back_ent), .dout_vld(back_vld)
	);

	evr_back u_back (
		.clk(clk), .arst_n(arst_n), .ent(back_ent), .ent_vld(back_vld),
		.done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w)
	);

endmodule
